[hw/rtl/jsu_pkg.sv]
// Shared types, constants and helpers for the JSON string unescaper.
package jsu_pkg;

	// Depth of the group queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	// Escape letters and the bytes they stand for
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_B         = 8'h62;
	localparam logic [7:0] CH_F         = 8'h66;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_U         = 8'h75;

	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_HT = 8'h09;

	// UTF-8 lead and continuation marks, range limits
	localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF_CONT  = 8'h80;
	localparam logic [15:0] LIM_ONE   = 16'h0080;
	localparam logic [15:0] LIM_TWO   = 16'h0800;

	// Group of up to three output bytes made by one input byte
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] cnt;   // 1..3 bytes valid
	} jsu_grp_t;

	// Hex digit to nibble; anything else gives zero
	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [3:0] n;
		n = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) n = c[3:0];
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			n = c[3:0] + 4'd9;
		return n;
	endfunction

endpackage

[hw/rtl/jsu_front.sv]
// Front end: escape state machine that turns text bytes into groups of output bytes.
module jsu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [7:0]       text_byte,
	output logic             in_stall,
	input  logic             q_full,
	output logic             push,
	output jsu_pkg::jsu_grp_t grp
);

	typedef enum logic [2:0] {
		PH_PLAIN = 3'd0,
		PH_ESC   = 3'd1,
		PH_HEX0  = 3'd2,
		PH_HEX1  = 3'd3,
		PH_HEX2  = 3'd4,
		PH_HEX3  = 3'd5
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] acc_q, acc_d;
	logic        accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Classify the byte against the current phase
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		grp     = '0;
		unique case (phase_q)
			PH_ESC: begin
				phase_d = PH_PLAIN;
				unique case (text_byte)
					jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH: begin
						grp.b0  = text_byte;
						grp.cnt = 2'd1;
					end
					jsu_pkg::CH_B: begin grp.b0 = jsu_pkg::CTL_BS; grp.cnt = 2'd1; end
					jsu_pkg::CH_F: begin grp.b0 = jsu_pkg::CTL_FF; grp.cnt = 2'd1; end
					jsu_pkg::CH_N: begin grp.b0 = jsu_pkg::CTL_LF; grp.cnt = 2'd1; end
					jsu_pkg::CH_R: begin grp.b0 = jsu_pkg::CTL_CR; grp.cnt = 2'd1; end
					jsu_pkg::CH_T: begin grp.b0 = jsu_pkg::CTL_HT; grp.cnt = 2'd1; end
					jsu_pkg::CH_U: begin
						acc_d   = '0;
						phase_d = PH_HEX0;
					end
					default: ;  // unknown escape: dropped
				endcase
			end
			PH_HEX0: begin
				acc_d   = {acc_q[11:0], jsu_pkg::hex_nibble(text_byte)};
				phase_d = PH_HEX1;
			end
			PH_HEX1: begin
				acc_d   = {acc_q[11:0], jsu_pkg::hex_nibble(text_byte)};
				phase_d = PH_HEX2;
			end
			PH_HEX2: begin
				acc_d   = {acc_q[11:0], jsu_pkg::hex_nibble(text_byte)};
				phase_d = PH_HEX3;
			end
			PH_HEX3: begin
				// last digit: encode the code point as UTF-8
				acc_d   = {acc_q[11:0], jsu_pkg::hex_nibble(text_byte)};
				phase_d = PH_PLAIN;
				if (acc_d < jsu_pkg::LIM_ONE) begin
					grp.b0  = acc_d[7:0];
					grp.cnt = 2'd1;
				end else if (acc_d < jsu_pkg::LIM_TWO) begin
					grp.b0  = jsu_pkg::UTF_LEAD2 | {3'b000, acc_d[10:6]};
					grp.b1  = jsu_pkg::UTF_CONT | {2'b00, acc_d[5:0]};
					grp.cnt = 2'd2;
				end else begin
					grp.b0  = jsu_pkg::UTF_LEAD3 | {4'b0000, acc_d[15:12]};
					grp.b1  = jsu_pkg::UTF_CONT | {2'b00, acc_d[11:6]};
					grp.b2  = jsu_pkg::UTF_CONT | {2'b00, acc_d[5:0]};
					grp.cnt = 2'd3;
				end
			end
			default: begin
				// plain text
				phase_d = PH_PLAIN;
				if (text_byte == jsu_pkg::CH_BACKSLASH) begin
					phase_d = PH_ESC;
				end else begin
					grp.b0  = text_byte;
					grp.cnt = 2'd1;
				end
			end
		endcase
	end

	assign push = accept && (grp.cnt != 2'd0);

	// Phase and code accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			acc_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
		end
	end

endmodule

[hw/rtl/jsu_fifo.sv]
// Short queue of byte groups between front and back.
module jsu_fifo #(
	parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jsu_pkg::jsu_grp_t wr_grp,
	input  logic              pop,
	output jsu_pkg::jsu_grp_t head,
	output logic              empty,
	output logic              full
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	jsu_pkg::jsu_grp_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_grp;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

[hw/rtl/jsu_back.sv]
// Back end: serialises queued groups into single bytes through an output register.
module jsu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  jsu_pkg::jsu_grp_t head,
	input  logic              q_empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              run_last
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       adv;
	logic       last;
	logic [7:0] sel_byte;

	assign adv  = !out_valid_q || !out_stall;
	assign last = (idx_q == head.cnt - 2'd1);
	assign pop  = adv && !q_empty && last;

	// Pick the current byte of the head group
	always_comb begin
		unique case (idx_q)
			2'd0:    sel_byte = head.b0;
			2'd1:    sel_byte = head.b1;
			default: sel_byte = head.b2;
		endcase
	end

	// Output register and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			run_last_q  <= 1'b0;
			out_byte_q  <= '0;
		end else if (adv) begin
			if (!q_empty) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= sel_byte;
				run_last_q  <= last;
				idx_q       <= last ? 2'd0 : idx_q + 2'd1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

endmodule

[hw/rtl/json_string_unescape_to_utf8_top.sv]
// Output bytes pass through the group queue and then the single output register.
// Throughput: one input byte per cycle while the queue has room, one output byte per
//   cycle unless stalled; a multi-byte u escape's two or three bytes leave back to back.
// The group queue (QUEUE_DEPTH entries) lets input continue while output is stalled.
// Reset (arst_n low, asynchronous) returns to plain text, clears the code and empties
//   the queue and output register.
module json_string_unescape_to_utf8_top #(
	parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last
);

	jsu_pkg::jsu_grp_t grp, head;
	logic              push, pop, q_empty, q_full;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.text_byte (text_byte),
		.in_stall  (in_stall),
		.q_full    (q_full),
		.push      (push),
		.grp       (grp)
	);

	jsu_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_grp (grp),
		.pop    (pop),
		.head   (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule

[hw/rtl/jsu_checker.sv]
// Port-level checks for the unescaper, bound to the top level.
module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] text_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       run_last
);

	// A stalled input transfer holds its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(text_byte))
		else $error("input changed while stalled");

	// A stalled output transfer holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("output changed while stalled");

	// Output stays idle through reset
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

	// Only multi-byte UTF-8 sequences have non-last bytes, all with the top bit set
	a_nonlast_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> out_byte[7])
		else $error("non-last byte is not part of a UTF-8 sequence");

	// The rest of a sequence follows without a gap
	a_seq_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |=> out_valid)
		else $error("gap inside a UTF-8 sequence");

endmodule

bind json_string_unescape_to_utf8_top jsu_checker u_jsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.text_byte (text_byte),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.run_last  (run_last)
);
